// ----- rtl/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types, constants and the remainder step for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int MOD_W      = 31;
    localparam int RED_W      = 64;
    localparam int RED_STEPS  = RED_W / 2;
    localparam int RED_CNT_W  = $clog2(RED_STEPS);

    localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic take_base;
        logic start_step;
        logic take_step;
    } mexp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic m_zero;
        logic exp_zero;
        logic done_sq;
        logic done_mul;
    } mexp_stat_t;

    // one restoring remainder step: shift in one bit, subtract modulus once
    function automatic logic [MOD_W-1:0] red_step(
        input logic [MOD_W-1:0] r,
        input logic             b,
        input logic [MOD_W-1:0] m
    );
        logic [MOD_W:0] t;
        logic [MOD_W:0] mx;
        t  = {r, b};
        mx = {1'b0, m};
        if (t >= mx)
        begin
            t = t - mx;
        end
        return t[MOD_W-1:0];
    endfunction

endpackage

// ----- rtl/mexp_red.sv -----
// ----------------------------------------------------------------------------
// mexp_red
// Serial remainder unit: reduces a 64-bit value modulo a 31-bit modulus,
// two bits per cycle, msb first.
// ----------------------------------------------------------------------------
module mexp_red
    import mexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [RED_W-1:0] din,
    input  logic [MOD_W-1:0] m,
    output logic [MOD_W-1:0] rem,
    output logic             done
);

    logic [RED_W-1:0]     sh_reg;
    logic [RED_W-1:0]     sh_next;
    logic [MOD_W-1:0]     r_reg;
    logic [MOD_W-1:0]     r_next;
    logic [MOD_W-1:0]     r_mid;
    logic [RED_CNT_W-1:0] cnt_reg;
    logic [RED_CNT_W-1:0] cnt_next;
    logic                 run_reg;
    logic                 run_next;
    logic                 done_reg;
    logic                 done_next;

    always_comb
    begin
        sh_next   = sh_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        r_mid     = red_step(r_reg, sh_reg[RED_W-1], m);
        if (load)
        begin
            sh_next  = din;
            r_next   = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            r_next   = red_step(r_mid, sh_reg[RED_W-2], m);
            sh_next  = {sh_reg[RED_W-3:0], 2'b00};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == RED_CNT_W'(RED_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        r_reg  <= r_next;
    end

    assign rem  = r_reg;
    assign done = done_reg;

endmodule

// ----- rtl/mexp_dp.sv -----
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: modulus register, running power and accumulator, exponent shift
// register, two multipliers each feeding its own remainder unit.
// ----------------------------------------------------------------------------
module mexp_dp
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = 63
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [MOD_W-1:0] cfg_wdata,
    input  logic [62:0]      base_value,
    input  logic [62:0]      exponent,
    input  mexp_cmd_t        cmd,
    output mexp_stat_t       stat,
    output logic [MOD_W-1:0] power_result
);

    logic [MOD_W-1:0]    m_reg;
    logic [MOD_W-1:0]    pw_reg;
    logic [MOD_W-1:0]    pw_next;
    logic [MOD_W-1:0]    acc_reg;
    logic [MOD_W-1:0]    acc_next;
    logic [EXP_BITS-1:0] exp_reg;
    logic [EXP_BITS-1:0] exp_next;
    logic [63:0]         exp_ext;
    logic [2*MOD_W-1:0]  prod_sq;
    logic [2*MOD_W-1:0]  prod_mul;
    logic [RED_W-1:0]    din_sq;
    logic [RED_W-1:0]    din_mul;
    logic                red_load;
    logic [MOD_W-1:0]    rem_sq;
    logic [MOD_W-1:0]    rem_mul;
    logic                done_sq;
    logic                done_mul;
    logic                m_small;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= MOD_RESET;
        end
        else if (cfg_we)
        begin
            m_reg <= cfg_wdata;
        end
    end

    assign exp_ext  = {1'b0, exponent};
    assign m_small  = (m_reg[MOD_W-1:1] == '0);
    assign prod_sq  = pw_reg * pw_reg;
    assign prod_mul = acc_reg * pw_reg;
    assign red_load = cmd.load | cmd.start_step;

    always_comb
    begin
        if (cmd.load)
        begin
            din_sq  = {1'b0, base_value};
            din_mul = '0;
        end
        else
        begin
            din_sq  = {{(RED_W - 2*MOD_W){1'b0}}, prod_sq};
            din_mul = {{(RED_W - 2*MOD_W){1'b0}}, prod_mul};
        end
    end

    always_comb
    begin
        pw_next  = pw_reg;
        acc_next = acc_reg;
        exp_next = exp_reg;
        if (cmd.load)
        begin
            // one mod m is zero for the trivial moduli
            acc_next = m_small ? '0 : MOD_W'(1);
            exp_next = exp_ext[EXP_BITS-1:0];
        end
        else if (cmd.take_base)
        begin
            pw_next = rem_sq;
        end
        else if (cmd.take_step)
        begin
            pw_next  = rem_sq;
            if (exp_reg[0])
            begin
                acc_next = rem_mul;
            end
            exp_next = exp_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        pw_reg  <= pw_next;
        acc_reg <= acc_next;
        exp_reg <= exp_next;
    end

    mexp_red u_red_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (red_load),
        .din   (din_sq),
        .m     (m_reg),
        .rem   (rem_sq),
        .done  (done_sq)
    );

    mexp_red u_red_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (red_load),
        .din   (din_mul),
        .m     (m_reg),
        .rem   (rem_mul),
        .done  (done_mul)
    );

    assign stat.m_zero   = (m_reg == '0);
    assign stat.exp_zero = (exp_reg == '0);
    assign stat.done_sq  = done_sq;
    assign stat.done_mul = done_mul;

    assign power_result = acc_reg;

endmodule

// ----- rtl/mexp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mexp_ctrl
// Controller: sequences base reduction, then one square-and-multiply round
// per exponent bit until the remaining exponent or the modulus is zero.
// ----------------------------------------------------------------------------
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  mexp_stat_t stat,
    output mexp_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_BASE = 5'b00010,
        S_STEP = 5'b00100,
        S_WAIT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.take_base  = 1'b0;
        cmd.start_step = 1'b0;
        cmd.take_step  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                if (stat.done_sq)
                begin
                    cmd.take_base = 1'b1;
                    state_next    = S_STEP;
                end
            end
            S_STEP:
            begin
                if (stat.exp_zero || stat.m_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.start_step = 1'b1;
                    state_next     = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (stat.done_sq)
                begin
                    cmd.take_step = 1'b1;
                    state_next    = S_STEP;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

// ----- rtl/modular_exponentiation.sv -----
// sequence: the accepting edge loads the operands, one pass reduces the base, then
//   one round per exponent bit up to the highest set bit (none for exponent 0 or modulus 0)
// the block takes no new item while busy; each exponent bit costs one pass of the
//   two serial remainder units (two bits per cycle)
// reset: async active low, returns to idle, modulus reloads 1000000007
// result beat lasts one cycle on done; the receiver cannot stall it
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square and multiply, base^exponent mod a configured modulus.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = 63
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [MOD_W-1:0] cfg_wdata,
    input  logic             start,
    input  logic [62:0]      base_value,
    input  logic [62:0]      exponent,
    output logic             busy,
    output logic             done,
    output logic [MOD_W-1:0] power_result
);

    mexp_cmd_t  cmd;
    mexp_stat_t stat;

    mexp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    mexp_dp #(
        .EXP_BITS (EXP_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .base_value   (base_value),
        .exponent     (exponent),
        .cmd          (cmd),
        .stat         (stat),
        .power_result (power_result)
    );

    // both remainder units are always started together
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done_sq == stat.done_mul)
        else $error("remainder units out of step");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted item did not make the block busy");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result beat longer than one cycle");

    a_reducer_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done_sq |-> busy)
        else $error("remainder unit finished while idle");

endmodule
